/* src/tehalloc_pkg.sv */
// Shared types, codes and constants of the two-ended audio RAM allocator.
`timescale 1ns / 1ps
`default_nettype none
package tehalloc_pkg;

    localparam int CUR_W  = 25;
    localparam int LEN_W  = 24;
    localparam int PTR_W  = 8;
    localparam int FUNC_W = 3;
    localparam int ST_W   = 3;
    localparam int STEP_W = 5;

    localparam logic [PTR_W-1:0] NIL          = 8'hFF;
    localparam logic [CUR_W-1:0] ZERO_AREA    = 25'd1280;
    localparam logic [CUR_W-1:0] ALIGN_MASK   = 25'd31;
    localparam logic [CUR_W-1:0] REGION_RESET = 25'd8421376;

    // Request kinds.
    localparam logic [FUNC_W-1:0] FN_STORE  = 3'd0;
    localparam logic [FUNC_W-1:0] FN_REMOVE = 3'd1;
    localparam logic [FUNC_W-1:0] FN_ALLOC  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_FREE   = 3'd3;
    localparam logic [FUNC_W-1:0] FN_QUERY  = 3'd4;

    // Result status codes.
    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_NO_ROOM  = 3'd1;
    localparam logic [ST_W-1:0] ST_UNDERFLOW = 3'd2;
    localparam logic [ST_W-1:0] ST_MISMATCH = 3'd3;
    localparam logic [ST_W-1:0] ST_BAD_SLOT = 3'd4;

    // Sequencer steps, shared by controller and datapath.
    localparam logic [STEP_W-1:0] S_INIT   = 5'd0;
    localparam logic [STEP_W-1:0] S_IDLE   = 5'd1;
    localparam logic [STEP_W-1:0] S_DISP   = 5'd2;
    localparam logic [STEP_W-1:0] S_Q_RD   = 5'd3;
    localparam logic [STEP_W-1:0] S_Q_CK   = 5'd4;
    localparam logic [STEP_W-1:0] S_F_RD   = 5'd5;
    localparam logic [STEP_W-1:0] S_F_CK   = 5'd6;
    localparam logic [STEP_W-1:0] S_F_UNL  = 5'd7;
    localparam logic [STEP_W-1:0] S_F_PUSH = 5'd8;
    localparam logic [STEP_W-1:0] S_M_RD   = 5'd9;
    localparam logic [STEP_W-1:0] S_M_CK   = 5'd10;
    localparam logic [STEP_W-1:0] S_W_RD   = 5'd11;
    localparam logic [STEP_W-1:0] S_W_CK   = 5'd12;
    localparam logic [STEP_W-1:0] S_W_LNK  = 5'd13;
    localparam logic [STEP_W-1:0] S_W_PUSH = 5'd14;
    localparam logic [STEP_W-1:0] S_W_END  = 5'd15;
    localparam logic [STEP_W-1:0] S_A_RD   = 5'd16;
    localparam logic [STEP_W-1:0] S_A_CK   = 5'd17;
    localparam logic [STEP_W-1:0] S_A_DEC  = 5'd18;
    localparam logic [STEP_W-1:0] S_A_LNK  = 5'd19;
    localparam logic [STEP_W-1:0] S_A_PUSH = 5'd20;
    localparam logic [STEP_W-1:0] S_A_IRD  = 5'd21;
    localparam logic [STEP_W-1:0] S_A_ICK  = 5'd22;
    localparam logic [STEP_W-1:0] S_DONE   = 5'd23;

    typedef struct packed {
        logic [STEP_W-1:0] step;
        logic              accept;
    } tehalloc_cmd_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              id_bad;
        logic              cur_nil;
        logic              hit;
        logic              prev_nil;
        logic              at_cursor;
        logic              remove;
        logic              exact;
        logic              best_nil;
        logic              best_prev_nil;
        logic              no_room;
        logic              init_last;
        logic              out_free;
    } tehalloc_stat_t;

endpackage
`default_nettype wire

/* src/two_ended_aram_heap_allocator_top.sv */
// Top level of the two-ended audio RAM allocator.
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Bus                    Contents
// s_        in         tuser[2:0]             request kind
//                      tdata[55:0]            length, claimed address, slot
// m_        out        tuser[2:0]             status
//                      tdata[63:0]            address, length, slot
// cfg_      in         cfg_we / cfg_wdata     region length register
//
// Store, remove and unknown requests pass through the dispatch and done
// steps before their result enters the output register. Query, free and
// allocate walk the linked slot lists in the slot memories with a read step
// and a check step per visited slot, because each list step waits on the
// registered read of the link memory. After reset and after every write of
// the region register, a pass over every slot rebuilds the idle list; no
// request is taken during it.
// A stalled result sits in the output register; the block takes the next
// request meanwhile and holds its own result until the register frees up.
module two_ended_aram_heap_allocator_top #(
    parameter int SLOTS     = 64,
    parameter int ADDR_BITS = 24
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [2:0]  s_tuser,   // func
    input  wire logic [55:0] s_tdata,   // req_length, req_address, slot_id
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [2:0]       m_tuser,   // status
    output logic [63:0]      m_tdata,   // addr_out, length_out, slot_out, zero pad
    input  wire logic        cfg_we,
    input  wire logic [24:0] cfg_wdata  // region_length
);
    import tehalloc_pkg::*;

    tehalloc_cmd_t    cmd;
    tehalloc_stat_t   stat;
    logic [ST_W-1:0]  m_st;
    logic [CUR_W-1:0] m_addr;
    logic [CUR_W-1:0] m_len;
    logic [PTR_W-1:0] m_slot;

    // The controller sequences each request; the datapath holds every cursor,
    // list head and slot memory and reports back the conditions it branches on.
    tehalloc_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .cfg_we(cfg_we), .stat(stat), .cmd(cmd)
    );

    tehalloc_dp #(.SLOTS(SLOTS), .ADDR_BITS(ADDR_BITS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .s_func(s_tuser), .s_len(s_tdata[23:0]), .s_addr(s_tdata[47:24]),
        .s_id(s_tdata[55:48]), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .m_valid_reg(m_tvalid), .m_tready(m_tready), .m_st_reg(m_st),
        .m_addr_reg(m_addr), .m_len_reg(m_len), .m_slot_reg(m_slot)
    );

    // Result fields packed from the lowest bit up, zero padded to 64 bits.
    assign m_tuser = m_st;
    assign m_tdata = {6'd0, m_slot, m_len, m_addr};
endmodule
`default_nettype wire

/* src/tehalloc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module tehalloc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                                  aclk,
    input  wire logic                                  we,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata_reg
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end
endmodule
`default_nettype wire

/* src/tehalloc_ctrl.sv */
// Sequencer state machine of the allocator.
`timescale 1ns / 1ps
`default_nettype none
module tehalloc_ctrl (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic                         cfg_we,
    input  wire tehalloc_pkg::tehalloc_stat_t stat,
    output tehalloc_pkg::tehalloc_cmd_t       cmd
);
    import tehalloc_pkg::*;

    logic [STEP_W-1:0] state_reg;
    logic [STEP_W-1:0] state_next;

    assign s_tready   = (state_reg == S_IDLE) && !cfg_we;
    assign cmd.step   = state_reg;
    assign cmd.accept = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_INIT:   if (stat.init_last) state_next = S_IDLE;
            S_IDLE:   if (cmd.accept) state_next = S_DISP;
            S_DISP: begin
                case (stat.func)
                    FN_ALLOC: state_next = S_A_RD;
                    FN_FREE:  state_next = stat.id_bad ? S_DONE : S_F_RD;
                    FN_QUERY: state_next = stat.id_bad ? S_DONE : S_Q_RD;
                    default:  state_next = S_DONE;
                endcase
            end
            S_Q_RD:   state_next = stat.cur_nil ? S_DONE : S_Q_CK;
            S_Q_CK:   state_next = stat.hit ? S_DONE : S_Q_RD;
            S_F_RD:   state_next = stat.cur_nil ? S_DONE : S_F_CK;
            S_F_CK: begin
                if (stat.hit) begin
                    state_next = stat.prev_nil ? S_F_PUSH : S_F_UNL;
                end else begin
                    state_next = S_F_RD;
                end
            end
            S_F_UNL:  state_next = S_F_PUSH;
            S_F_PUSH: state_next = stat.at_cursor ? S_M_RD : S_DONE;
            S_M_RD:   state_next = stat.cur_nil ? S_W_RD : S_M_CK;
            S_M_CK:   state_next = S_M_RD;
            S_W_RD:   state_next = stat.cur_nil ? S_W_END : S_W_CK;
            S_W_CK: begin
                if (stat.remove) begin
                    state_next = stat.prev_nil ? S_W_PUSH : S_W_LNK;
                end else begin
                    state_next = S_W_RD;
                end
            end
            S_W_LNK:  state_next = S_W_PUSH;
            S_W_PUSH: state_next = S_W_RD;
            S_W_END:  state_next = S_DONE;
            S_A_RD:   state_next = stat.cur_nil ? S_A_DEC : S_A_CK;
            S_A_CK:   state_next = stat.exact ? S_A_DEC : S_A_RD;
            S_A_DEC: begin
                if (!stat.best_nil) begin
                    state_next = stat.best_prev_nil ? S_A_PUSH : S_A_LNK;
                end else begin
                    state_next = stat.no_room ? S_DONE : S_A_IRD;
                end
            end
            S_A_LNK:  state_next = S_A_PUSH;
            S_A_PUSH: state_next = S_DONE;
            S_A_IRD:  state_next = S_A_ICK;
            S_A_ICK:  state_next = S_DONE;
            S_DONE:   if (stat.out_free) state_next = S_IDLE;
            default:  state_next = S_INIT;
        endcase
        if (cfg_we) begin
            state_next = S_INIT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    a_done_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DONE && stat.out_free && !cfg_we |=> state_reg == S_IDLE)
        else $error("finished request did not return to idle");
    a_accept_disp: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> state_reg == S_DISP)
        else $error("accepted request not dispatched");
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> state_reg == S_IDLE)
        else $error("ready outside the idle state");
endmodule
`default_nettype wire

/* src/tehalloc_dp.sv */
// Datapath: cursors, list heads, walk registers, slot memories, output register.
`timescale 1ns / 1ps
`default_nettype none
module tehalloc_dp #(
    parameter int SLOTS     = 64,
    parameter int ADDR_BITS = 24
) (
    input  wire logic                                     aclk,
    input  wire logic                                     aresetn,
    input  wire tehalloc_pkg::tehalloc_cmd_t              cmd,
    output tehalloc_pkg::tehalloc_stat_t                  stat,
    input  wire logic [tehalloc_pkg::FUNC_W-1:0]          s_func,
    input  wire logic [tehalloc_pkg::LEN_W-1:0]           s_len,
    input  wire logic [tehalloc_pkg::LEN_W-1:0]           s_addr,
    input  wire logic [tehalloc_pkg::PTR_W-1:0]           s_id,
    input  wire logic                                     cfg_we,
    input  wire logic [tehalloc_pkg::CUR_W-1:0]           cfg_wdata,
    output logic                                          m_valid_reg,
    input  wire logic                                     m_tready,
    output logic [tehalloc_pkg::ST_W-1:0]                 m_st_reg,
    output logic [tehalloc_pkg::CUR_W-1:0]                m_addr_reg,
    output logic [tehalloc_pkg::CUR_W-1:0]                m_len_reg,
    output logic [tehalloc_pkg::PTR_W-1:0]                m_slot_reg
);
    import tehalloc_pkg::*;

    localparam int IDX_W = $clog2(SLOTS > 1 ? SLOTS : 2);
    localparam logic [32:0] CAP = 33'd1 << ADDR_BITS;
    localparam logic [PTR_W-1:0] SLOT_CNT = PTR_W'(SLOTS);

    logic [CUR_W-1:0]  region_reg, region_next;
    logic [CUR_W-1:0]  sample_reg, sample_next;
    logic [CUR_W-1:0]  stream_reg, stream_next;
    logic [PTR_W-1:0]  used_head_reg, used_head_next;
    logic [PTR_W-1:0]  free_head_reg, free_head_next;
    logic [PTR_W-1:0]  idle_head_reg, idle_head_next;
    logic [PTR_W-1:0]  cur_reg, cur_next;
    logic [PTR_W-1:0]  prev_reg, prev_next;
    logic [PTR_W-1:0]  best_reg, best_next;
    logic [PTR_W-1:0]  best_prev_reg, best_prev_next;
    logic [CUR_W-1:0]  best_len_reg, best_len_next;
    logic [PTR_W-1:0]  hold_next_reg, hold_next_next;
    logic [CUR_W-1:0]  hold_addr_reg, hold_addr_next;
    logic [CUR_W-1:0]  min_reg, min_next;
    logic              have_min_reg, have_min_next;
    logic [IDX_W-1:0]  cnt_reg, cnt_next;
    logic [FUNC_W-1:0] func_reg, func_next;
    logic [CUR_W-1:0]  alen_reg, alen_next;
    logic [LEN_W-1:0]  claim_reg, claim_next;
    logic [PTR_W-1:0]  id_reg, id_next;
    logic [ST_W-1:0]   res_st_reg, res_st_next;
    logic [CUR_W-1:0]  res_addr_reg, res_addr_next;
    logic [CUR_W-1:0]  res_len_reg, res_len_next;
    logic [PTR_W-1:0]  res_slot_reg, res_slot_next;
    logic              m_valid_next;

    logic [PTR_W-1:0]  rd_nx;
    logic [CUR_W-1:0]  rd_addr, rd_len, rd_carved;
    logic [PTR_W-1:0]  raddr;
    logic              next_we, len_we, cv_we;
    logic [PTR_W-1:0]  next_wa;
    logic [PTR_W-1:0]  next_wd;

    logic [CUR_W-1:0]  capped, top, floor_c, room, sample_pop, stream_carve;
    logic [IDX_W:0]    cnt_inc;
    logic              load_out;

    // Region top and the sample floor follow from the region register.
    assign capped  = ({8'd0, region_reg} > CAP) ? CAP[CUR_W-1:0] : region_reg;
    assign top     = (capped < ZERO_AREA) ? '0 : capped;
    assign floor_c = (top < ZERO_AREA) ? top : ZERO_AREA;
    assign room    = (stream_reg > sample_reg) ? stream_reg - sample_reg : '0;
    assign sample_pop   = sample_reg - alen_reg;
    assign stream_carve = stream_reg - alen_reg;
    assign cnt_inc = {1'b0, cnt_reg} + 1'b1;

    assign stat.func          = func_reg;
    assign stat.id_bad        = id_reg >= SLOT_CNT;
    assign stat.cur_nil       = cur_reg >= SLOT_CNT;
    assign stat.hit           = cur_reg == id_reg;
    assign stat.prev_nil      = prev_reg == NIL;
    assign stat.at_cursor     = hold_addr_reg == stream_reg;
    assign stat.remove        = !have_min_reg || (rd_addr < min_reg);
    assign stat.exact         = rd_carved == alen_reg;
    assign stat.best_nil      = best_reg == NIL;
    assign stat.best_prev_nil = best_prev_reg == NIL;
    assign stat.no_room       = (idle_head_reg >= SLOT_CNT) || (alen_reg > room);
    assign stat.init_last     = cnt_reg == IDX_W'(SLOTS - 1);
    assign stat.out_free      = !m_valid_reg || m_tready;

    assign load_out = (cmd.step == S_DONE) && stat.out_free;
    assign raddr    = (cmd.step == S_A_IRD) ? best_reg : cur_reg;

    always_comb begin
        region_next    = region_reg;
        sample_next    = sample_reg;
        stream_next    = stream_reg;
        used_head_next = used_head_reg;
        free_head_next = free_head_reg;
        idle_head_next = idle_head_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        best_next      = best_reg;
        best_prev_next = best_prev_reg;
        best_len_next  = best_len_reg;
        hold_next_next = hold_next_reg;
        hold_addr_next = hold_addr_reg;
        min_next       = min_reg;
        have_min_next  = have_min_reg;
        cnt_next       = cnt_reg;
        func_next      = func_reg;
        alen_next      = alen_reg;
        claim_next     = claim_reg;
        id_next        = id_reg;
        res_st_next    = res_st_reg;
        res_addr_next  = res_addr_reg;
        res_len_next   = res_len_reg;
        res_slot_next  = res_slot_reg;
        next_we = 1'b0;
        len_we  = 1'b0;
        cv_we   = 1'b0;
        next_wa = best_reg;
        next_wd = used_head_reg;

        case (cmd.step)
            S_INIT: begin
                next_we = 1'b1;
                next_wa = PTR_W'(cnt_reg);
                next_wd = (cnt_inc < (IDX_W + 1)'(SLOTS)) ? PTR_W'(cnt_inc) : NIL;
                cnt_next       = cnt_inc[IDX_W-1:0];
                sample_next    = floor_c;
                stream_next    = top;
                used_head_next = NIL;
                free_head_next = NIL;
                idle_head_next = '0;
            end
            S_IDLE: begin
                if (cmd.accept) begin
                    func_next     = s_func;
                    alen_next     = ({1'b0, s_len} + ALIGN_MASK) & ~ALIGN_MASK;
                    claim_next    = s_addr;
                    id_next       = s_id;
                    res_st_next   = ST_OK;
                    res_addr_next = '0;
                    res_len_next  = '0;
                    res_slot_next = NIL;
                end
            end
            S_DISP: begin
                prev_next = NIL;
                best_next = NIL;
                case (func_reg)
                    FN_STORE: begin
                        if (alen_reg == '0) begin
                            res_addr_next = sample_reg;
                        end else if (alen_reg > room) begin
                            res_st_next = ST_NO_ROOM;
                        end else begin
                            res_addr_next = sample_reg;
                            sample_next   = sample_reg + alen_reg;
                        end
                    end
                    FN_REMOVE: begin
                        if (sample_reg < ZERO_AREA || alen_reg > sample_reg - ZERO_AREA) begin
                            sample_next = floor_c;
                            res_st_next = ST_UNDERFLOW;
                        end else begin
                            sample_next = sample_pop;
                            if ({1'b0, claim_reg} != sample_pop) begin
                                res_st_next = ST_MISMATCH;
                            end
                        end
                    end
                    FN_ALLOC: cur_next = free_head_reg;
                    FN_FREE, FN_QUERY: begin
                        cur_next = used_head_reg;
                        if (stat.id_bad) begin
                            res_st_next = ST_BAD_SLOT;
                        end
                    end
                    default: ;
                endcase
            end
            S_Q_RD, S_F_RD: begin
                if (stat.cur_nil) begin
                    res_st_next = ST_BAD_SLOT;
                end
            end
            S_Q_CK: begin
                if (stat.hit) begin
                    res_addr_next = rd_addr;
                    res_len_next  = rd_len;
                end else begin
                    cur_next = rd_nx;
                end
            end
            S_F_CK: begin
                if (stat.hit) begin
                    hold_next_next = rd_nx;
                    hold_addr_next = rd_addr;
                    if (stat.prev_nil) begin
                        used_head_next = rd_nx;
                    end
                end else begin
                    prev_next = cur_reg;
                    cur_next  = rd_nx;
                end
            end
            S_F_UNL, S_W_LNK: begin
                next_we = 1'b1;
                next_wa = prev_reg;
                next_wd = hold_next_reg;
            end
            S_F_PUSH: begin
                next_we = 1'b1;
                next_wa = id_reg;
                if (stat.at_cursor) begin
                    next_wd        = idle_head_reg;
                    idle_head_next = id_reg;
                    cur_next       = used_head_reg;
                    have_min_next  = 1'b0;
                end else begin
                    next_wd        = free_head_reg;
                    free_head_next = id_reg;
                end
            end
            S_M_RD: begin
                if (stat.cur_nil) begin
                    cur_next  = free_head_reg;
                    prev_next = NIL;
                end
            end
            S_M_CK: begin
                if (!have_min_reg || rd_addr <= min_reg) begin
                    min_next      = rd_addr;
                    have_min_next = 1'b1;
                end
                cur_next = rd_nx;
            end
            S_W_CK: begin
                hold_next_next = rd_nx;
                if (stat.remove) begin
                    if (stat.prev_nil) begin
                        free_head_next = rd_nx;
                    end
                end else begin
                    prev_next = cur_reg;
                    cur_next  = rd_nx;
                end
            end
            S_W_PUSH: begin
                next_we        = 1'b1;
                next_wa        = cur_reg;
                next_wd        = idle_head_reg;
                idle_head_next = cur_reg;
                cur_next       = hold_next_reg;
            end
            S_W_END: stream_next = have_min_reg ? min_reg : top;
            S_A_CK: begin
                if (stat.exact ||
                    (rd_carved > alen_reg && (stat.best_nil || rd_carved < best_len_reg))) begin
                    best_next      = cur_reg;
                    best_prev_next = prev_reg;
                    best_len_next  = rd_carved;
                    hold_next_next = rd_nx;
                    hold_addr_next = rd_addr;
                end
                prev_next = cur_reg;
                cur_next  = rd_nx;
            end
            S_A_DEC: begin
                if (!stat.best_nil) begin
                    if (stat.best_prev_nil) begin
                        free_head_next = hold_next_reg;
                    end
                end else if (stat.no_room) begin
                    res_st_next = ST_NO_ROOM;
                end else begin
                    best_next = idle_head_reg;
                end
            end
            S_A_LNK: begin
                next_we = 1'b1;
                next_wa = best_prev_reg;
                next_wd = hold_next_reg;
            end
            S_A_PUSH: begin
                next_we        = 1'b1;
                len_we         = 1'b1;
                used_head_next = best_reg;
                res_addr_next  = hold_addr_reg;
                res_slot_next  = best_reg;
            end
            S_A_ICK: begin
                next_we        = 1'b1;
                len_we         = 1'b1;
                cv_we          = 1'b1;
                idle_head_next = rd_nx;
                stream_next    = stream_carve;
                used_head_next = best_reg;
                res_addr_next  = stream_carve;
                res_slot_next  = best_reg;
            end
            default: ;
        endcase

        if (cfg_we) begin
            region_next = cfg_wdata;
            cnt_next    = '0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            region_reg  <= REGION_RESET;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            region_reg  <= region_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sample_reg    <= sample_next;
        stream_reg    <= stream_next;
        used_head_reg <= used_head_next;
        free_head_reg <= free_head_next;
        idle_head_reg <= idle_head_next;
        cur_reg       <= cur_next;
        prev_reg      <= prev_next;
        best_reg      <= best_next;
        best_prev_reg <= best_prev_next;
        best_len_reg  <= best_len_next;
        hold_next_reg <= hold_next_next;
        hold_addr_reg <= hold_addr_next;
        min_reg       <= min_next;
        have_min_reg  <= have_min_next;
        func_reg      <= func_next;
        alen_reg      <= alen_next;
        claim_reg     <= claim_next;
        id_reg        <= id_next;
        res_st_reg    <= res_st_next;
        res_addr_reg  <= res_addr_next;
        res_len_reg   <= res_len_next;
        res_slot_reg  <= res_slot_next;
        if (load_out) begin
            m_st_reg   <= res_st_reg;
            m_addr_reg <= res_addr_reg;
            m_len_reg  <= res_len_reg;
            m_slot_reg <= res_slot_reg;
        end
    end

    tehalloc_ram #(.WIDTH(PTR_W), .DEPTH(SLOTS)) u_next_ram (
        .aclk(aclk), .we(next_we), .waddr(next_wa[IDX_W-1:0]), .wdata(next_wd),
        .raddr(raddr[IDX_W-1:0]), .rdata_reg(rd_nx)
    );
    tehalloc_ram #(.WIDTH(CUR_W), .DEPTH(SLOTS)) u_addr_ram (
        .aclk(aclk), .we(cv_we), .waddr(best_reg[IDX_W-1:0]), .wdata(stream_carve),
        .raddr(raddr[IDX_W-1:0]), .rdata_reg(rd_addr)
    );
    tehalloc_ram #(.WIDTH(CUR_W), .DEPTH(SLOTS)) u_len_ram (
        .aclk(aclk), .we(len_we), .waddr(best_reg[IDX_W-1:0]), .wdata(alen_reg),
        .raddr(raddr[IDX_W-1:0]), .rdata_reg(rd_len)
    );
    tehalloc_ram #(.WIDTH(CUR_W), .DEPTH(SLOTS)) u_carved_ram (
        .aclk(aclk), .we(cv_we), .waddr(best_reg[IDX_W-1:0]), .wdata(alen_reg),
        .raddr(raddr[IDX_W-1:0]), .rdata_reg(rd_carved)
    );

    a_link_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        next_we |-> next_wa < SLOT_CNT)
        else $error("link write outside the slot table");
    a_carve_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step == S_A_ICK |-> best_reg < SLOT_CNT)
        else $error("carve without an idle slot");
    a_free_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step == S_F_PUSH |-> id_reg < SLOT_CNT)
        else $error("free of an out-of-range slot");
endmodule
`default_nettype wire
